@@ rtl/ffck_pkg.sv @@
// ----------------------------------------------------------------------------
// ffck_pkg
// key codes, operation codes and shared constants for the key calculator
// ----------------------------------------------------------------------------
package ffck_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 64;

    localparam logic [1:0] MODE_DIGIT  = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_EQUALS = 2'd2;
    localparam logic [1:0] MODE_OPER   = 2'd3;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [63:0] ENTRY_LIMIT = 64'd999999999999;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic       zero_div_held;
    } ffck_cmd_t;

endpackage

@@ rtl/ffck_alu.sv @@
// ----------------------------------------------------------------------------
// ffck_alu
// bit-serial add, subtract, shift-add multiply and restoring divide
// ----------------------------------------------------------------------------
module ffck_alu
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffck_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam logic [CW-1:0] LAST = CW'(VALUE_WIDTH - 1);

    logic                   busy_reg, busy_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [2:0]             op_reg, op_next;
    logic                   zh_reg, zh_next;
    logic                   neg_reg, neg_next;
    logic                   carry_reg, carry_next;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] hold_reg, hold_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH-1:0] mag_a, mag_b;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] rem_sh;
    logic                   sbit, cbit;

    assign mag_a  = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
    assign mag_b  = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;
    assign rem_sh = {acc_reg[VALUE_WIDTH-2:0], x_reg[VALUE_WIDTH-1]};
    assign trial  = {acc_reg, x_reg[VALUE_WIDTH-1]} - {1'b0, y_reg};
    assign {cbit, sbit} = {1'b0, x_reg[0]} + {1'b0, (op_reg == OP_SUB) ? ~y_reg[0] : y_reg[0]}
                          + {1'b0, carry_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        zh_next    = zh_reg;
        neg_next   = neg_reg;
        carry_next = carry_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        hold_next  = hold_reg;
        done_next  = 1'b0;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            op_next    = cmd.op;
            zh_next    = cmd.zero_div_held;
            hold_next  = a;
            acc_next   = '0;
            carry_next = (cmd.op == OP_SUB);
            neg_next   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
            if (cmd.op == OP_DIV)
            begin
                x_next = mag_a;
                y_next = mag_b;
            end
            else
            begin
                x_next = a;
                y_next = b;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            case (op_reg)
                OP_ADD, OP_SUB:
                begin
                    x_next     = {sbit, x_reg[VALUE_WIDTH-1:1]};
                    y_next     = {1'b0, y_reg[VALUE_WIDTH-1:1]};
                    carry_next = cbit;
                end
                OP_MUL:
                begin
                    if (y_reg[0])
                        acc_next = acc_reg + x_reg;
                    x_next = {x_reg[VALUE_WIDTH-2:0], 1'b0};
                    y_next = {1'b0, y_reg[VALUE_WIDTH-1:1]};
                end
                OP_DIV:
                begin
                    if (!trial[VALUE_WIDTH])
                    begin
                        acc_next = trial[VALUE_WIDTH-1:0];
                        x_next   = {x_reg[VALUE_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh;
                        x_next   = {x_reg[VALUE_WIDTH-2:0], 1'b0};
                    end
                end
                default:
                begin
                end
            endcase
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:
            begin
                if (y_reg == '0)
                    result = zh_reg ? hold_reg : '0;
                else
                    result = neg_reg ? (~x_reg + 1'b1) : x_reg;
            end
            default: result = x_reg;
        endcase
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_NONE;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zh_reg    <= zh_next;
        neg_reg   <= neg_next;
        carry_reg <= carry_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        hold_reg  <= hold_next;
    end

endmodule

@@ rtl/four_function_calculator_keys.sv @@
// ----------------------------------------------------------------------------
// four_function_calculator_keys
// key-driven four-function calculator with a bit-serial arithmetic unit
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// key     | key_valid key_stall mode digit operation  | in
// result  | res_valid res_stall shown_value waiting_op entry_fresh | out
//
// digit, clear, and keys with nothing to compute go from idle straight to the result state
// equals and chained operators run the serial unit, then go to the result state
// the serial unit handles one bit per cycle for every operation
// reset clears the state to zero entry, no operation, fresh entry
// a held result stalls the key channel until it is taken
// ----------------------------------------------------------------------------
module four_function_calculator_keys
    import ffck_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  digit,
    input  logic [1:0]  operation,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [63:0] shown_value,
    output logic [2:0]  waiting_op,
    output logic        entry_fresh
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] entry_reg, entry_next;
    logic [VALUE_WIDTH-1:0] held_reg, held_next;
    logic [2:0]             pend_reg, pend_next;
    logic                   fresh_reg, fresh_next;
    logic                   oper_reg, oper_next;
    logic [2:0]             newop_reg, newop_next;
    ffck_cmd_t              cmd;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;
    logic [VALUE_WIDTH-1:0] mag_entry;
    logic [63:0]            mag_ext;
    logic [VALUE_WIDTH-1:0] times_ten;
    logic [VALUE_WIDTH-1:0] dig_ext;
    logic                   take;

    assign key_stall = (state_reg != ST_IDLE);
    assign take      = key_valid && !key_stall;
    assign res_valid = (state_reg == ST_OUT);
    assign shown_value = 64'($signed(entry_reg));
    assign waiting_op  = pend_reg;
    assign entry_fresh = fresh_reg;

    assign mag_entry = entry_reg[VALUE_WIDTH-1] ? (~entry_reg + 1'b1) : entry_reg;
    assign mag_ext   = 64'(mag_entry);
    assign times_ten = {entry_reg[VALUE_WIDTH-4:0], 3'b000} + {entry_reg[VALUE_WIDTH-2:0], 1'b0};
    assign dig_ext   = VALUE_WIDTH'(digit);

    ffck_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (held_reg),
        .b      (entry_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        fresh_next = fresh_reg;
        oper_next  = oper_reg;
        newop_next = newop_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_OUT;
                    case (mode)
                        MODE_DIGIT:
                        begin
                            if (digit <= 4'd9)
                            begin
                                if (fresh_reg)
                                begin
                                    entry_next = dig_ext;
                                    fresh_next = 1'b0;
                                end
                                else if (mag_ext < ENTRY_LIMIT || entry_reg[VALUE_WIDTH-1])
                                begin
                                    if (!entry_reg[VALUE_WIDTH-1])
                                        entry_next = times_ten + dig_ext;
                                    else if (mag_ext < ENTRY_LIMIT)
                                        entry_next = times_ten - dig_ext;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            entry_next = '0;
                            held_next  = '0;
                            pend_next  = OP_NONE;
                            fresh_next = 1'b1;
                        end
                        MODE_EQUALS:
                        begin
                            if (pend_reg != OP_NONE)
                            begin
                                cmd.start  = 1'b1;
                                cmd.op     = pend_reg;
                                oper_next  = 1'b0;
                                state_next = ST_CALC;
                            end
                        end
                        default:
                        begin
                            newop_next = {1'b0, operation} + 3'd1;
                            if (pend_reg != OP_NONE && !fresh_reg)
                            begin
                                cmd.start         = 1'b1;
                                cmd.op            = pend_reg;
                                cmd.zero_div_held = 1'b1;
                                oper_next         = 1'b1;
                                state_next        = ST_CALC;
                            end
                            else
                            begin
                                held_next  = entry_reg;
                                pend_next  = {1'b0, operation} + 3'd1;
                                fresh_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                if (alu_done)
                begin
                    entry_next = alu_result;
                    fresh_next = 1'b1;
                    state_next = ST_OUT;
                    if (oper_reg)
                    begin
                        held_next = alu_result;
                        pend_next = newop_reg;
                    end
                    else
                        pend_next = OP_NONE;
                end
            end
            ST_OUT:
            begin
                if (!res_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            entry_reg <= '0;
            held_reg  <= '0;
            pend_reg  <= OP_NONE;
            fresh_reg <= 1'b1;
            oper_reg  <= 1'b0;
            newop_reg <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            fresh_reg <= fresh_next;
            oper_reg  <= oper_next;
            newop_reg <= newop_next;
        end
    end

endmodule

@@ rtl/ffck_checker.sv @@
// ----------------------------------------------------------------------------
// ffck_checker
// port-level checks for the key calculator
// ----------------------------------------------------------------------------
module ffck_checker
    import ffck_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        key_valid,
    input logic        key_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [63:0] shown_value,
    input logic [2:0]  waiting_op,
    input logic        entry_fresh
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(shown_value)
            && $stable(waiting_op) && $stable(entry_fresh))
        else $error("stalled result changed");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> key_stall)
        else $error("key taken while result pending");

    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> waiting_op <= OP_DIV)
        else $error("pending operation out of range");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall |=> !res_valid || key_stall)
        else $error("key transfer left the input open");

endmodule

bind four_function_calculator_keys ffck_checker u_ffck_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .shown_value (shown_value),
    .waiting_op  (waiting_op),
    .entry_fresh (entry_fresh)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// key sequences into the calculator, each result checked against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ffck_pkg::*;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] digit;
        logic [1:0] operation;
    } key_t;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  op;
        logic        fresh;
    } display_t;

    logic        clk;
    logic        rst_n;
    logic        key_valid;
    logic        key_stall;
    logic [1:0]  mode;
    logic [3:0]  digit;
    logic [1:0]  operation;
    logic        res_valid;
    logic        res_stall;
    logic [63:0] shown_value;
    logic [2:0]  waiting_op;
    logic        entry_fresh;

    key_t     key_queue[$];
    display_t display_queue[$];
    int       errors;
    int       cycles;
    int       send_idle;
    int       recv_idle;
    bit       done_feeding;

    logic [63:0] calc_entry;
    logic [63:0] calc_held;
    logic [2:0]  calc_op;
    logic        calc_fresh;

    four_function_calculator_keys u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .mode       (mode),
        .digit      (digit),
        .operation  (operation),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .shown_value(shown_value),
        .waiting_op (waiting_op),
        .entry_fresh(entry_fresh)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [63:0] abs64(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] arith(logic [63:0] a, logic [63:0] b, logic [2:0] op,
                                          logic [63:0] zero_div);
        logic [63:0] q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_DIV:
            begin
                if (b == 64'd0)
                    return zero_div;
                q = abs64(a) / abs64(b);
                return (a[63] != b[63]) ? 64'd0 - q : q;
            end
            default: return a;
        endcase
    endfunction

    task automatic press_key(key_t k);
        display_t d;
        case (k.mode)
            MODE_DIGIT:
            begin
                if (k.digit <= 4'd9)
                begin
                    if (calc_fresh)
                    begin
                        calc_entry = {60'd0, k.digit};
                        calc_fresh = 1'b0;
                    end
                    else if (abs64(calc_entry) < ENTRY_LIMIT)
                        calc_entry = calc_entry[63] ? calc_entry * 10 - k.digit
                                                    : calc_entry * 10 + k.digit;
                end
            end
            MODE_CLEAR:
            begin
                calc_entry = '0;
                calc_held  = '0;
                calc_op    = OP_NONE;
                calc_fresh = 1'b1;
            end
            MODE_EQUALS:
            begin
                if (calc_op != OP_NONE)
                begin
                    calc_entry = arith(calc_held, calc_entry, calc_op, 64'd0);
                    calc_op    = OP_NONE;
                    calc_fresh = 1'b1;
                end
            end
            default:
            begin
                if (calc_op != OP_NONE && !calc_fresh)
                    calc_entry = arith(calc_held, calc_entry, calc_op, calc_held);
                calc_held  = calc_entry;
                calc_op    = 3'(k.operation) + 3'd1;
                calc_fresh = 1'b1;
            end
        endcase
        d.value = calc_entry;
        d.op    = calc_op;
        d.fresh = calc_fresh;
        display_queue.push_back(d);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic key_t mk(logic [1:0] m, logic [3:0] d, logic [1:0] o);
        key_t k;
        k.mode = m;
        k.digit = d;
        k.operation = o;
        return k;
    endfunction

    task automatic push_number(logic [63:0] n);
        string s;
        s = $sformatf("%0d", n);
        foreach (s[i])
            key_queue.push_back(mk(MODE_DIGIT, 4'(s[i] - "0"), 2'($urandom)));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid <= 1'b0;
        end
        else if (!key_valid || !key_stall)
        begin
            if (key_valid)
                press_key({mode, digit, operation});
            if (key_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                key_t k;
                k = key_queue.pop_front();
                key_valid <= 1'b1;
                mode      <= k.mode;
                digit     <= k.digit;
                operation <= k.operation;
            end
            else
                key_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (display_queue.size() == 0)
                    report("unexpected transfer", shown_value, 64'd0);
                else
                begin
                    display_t e;
                    e = display_queue.pop_front();
                    if (shown_value !== e.value)
                        report("shown_value", shown_value, e.value);
                    if (waiting_op !== e.op)
                        report("waiting_op", 64'(waiting_op), 64'(e.op));
                    if (entry_fresh !== e.fresh)
                        report("entry_fresh", 64'(entry_fresh), 64'(e.fresh));
                end
            end
            res_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] big;
        errors = 0;
        cycles = 0;
        send_idle = 34;
        recv_idle = 69;
        key_valid = 1'b0;
        mode = MODE_DIGIT;
        digit = '0;
        operation = '0;
        res_stall = 1'b0;
        calc_entry = '0;
        calc_held = '0;
        calc_op = OP_NONE;
        calc_fresh = 1'b1;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: digits, ignored digits, limit, every op, zero division
        key_queue.push_back(mk(MODE_EQUALS, 4'd0, 2'd0));
        key_queue.push_back(mk(MODE_DIGIT, 4'd15, 2'd3));
        key_queue.push_back(mk(MODE_DIGIT, 4'd10, 2'd0));
        for (int i = 0; i < 14; i++)
            key_queue.push_back(mk(MODE_DIGIT, 4'd9, 2'd0));
        for (int o = 0; o < 4; o++)
        begin
            key_queue.push_back(mk(MODE_OPER, 4'd0, 2'(o)));
            key_queue.push_back(mk(MODE_DIGIT, 4'd7, 2'd0));
        end
        key_queue.push_back(mk(MODE_OPER, 4'd0, 2'd3));
        key_queue.push_back(mk(MODE_DIGIT, 4'd0, 2'd0));
        key_queue.push_back(mk(MODE_OPER, 4'd0, 2'd3));
        key_queue.push_back(mk(MODE_DIGIT, 4'd0, 2'd0));
        key_queue.push_back(mk(MODE_EQUALS, 4'd0, 2'd0));
        key_queue.push_back(mk(MODE_CLEAR, 4'd0, 2'd0));

        for (int n = 0; n < 205; n++)
        begin
            int r;
            r = $urandom_range(99);
            if (r < 8)
                key_queue.push_back(mk(2'($urandom), 4'($urandom), 2'($urandom)));
            else if (r < 12)
                key_queue.push_back(mk(MODE_CLEAR, 4'($urandom), 2'($urandom)));
            else
            begin
                // operand: short number, or a large one for wrap and sign paths
                if ($urandom_range(3) == 0)
                    big = {$urandom, $urandom};
                else
                    big = $urandom_range(999);
                if (big[63])
                begin
                    // negative entry: 0 - x then continue as chain operand
                    key_queue.push_back(mk(MODE_DIGIT, 4'd0, 2'd0));
                    key_queue.push_back(mk(MODE_OPER, 4'd0, 2'd1));
                    big = abs64(big) % 64'd10000000000000;
                end
                push_number(big);
                if ($urandom_range(4) == 0)
                    key_queue.push_back(mk(MODE_DIGIT, 4'($urandom_range(15)), 2'd0));
                if ($urandom_range(2) == 0)
                    key_queue.push_back(mk(MODE_EQUALS, 4'($urandom), 2'($urandom)));
                key_queue.push_back(mk(MODE_OPER, 4'($urandom), 2'($urandom)));
                if ($urandom_range(5) == 0)
                    key_queue.push_back(mk(MODE_OPER, 4'($urandom), 2'($urandom)));
                if ($urandom_range(6) == 0)
                    key_queue.push_back(mk(MODE_DIGIT, 4'd0, 2'd0));
            end
            if (n == 68)
            begin
                wait (key_queue.size() == 0);
                send_idle = 69;
                recv_idle = 34;
            end
            if (n == 136)
            begin
                wait (key_queue.size() == 0);
                send_idle = 0;
                recv_idle = 0;
            end
        end

        wait (key_queue.size() == 0);
        @(posedge clk);
        while (key_valid || display_queue.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ffck_pkg.sv
rtl/ffck_alu.sv
rtl/four_function_calculator_keys.sv
rtl/ffck_checker.sv
bench/testbench.sv
